@@ hw/rtl/bpmb_pkg.sv @@
// Shared opcode constants and sequencer state type for the bit-packed message buffer.
package bpmb_pkg;

	localparam logic [3:0] OP_CLEAR      = 4'd0;
	localparam logic [3:0] OP_WRITE_BITS = 4'd1;
	localparam logic [3:0] OP_WRITE_BIT  = 4'd2;
	localparam logic [3:0] OP_WRITE_BYTE = 4'd3;
	localparam logic [3:0] OP_BEGIN_READ = 4'd4;
	localparam logic [3:0] OP_READ_BITS  = 4'd5;
	localparam logic [3:0] OP_READ_BIT   = 4'd6;
	localparam logic [3:0] OP_READ_BYTE  = 4'd7;
	localparam logic [3:0] OP_READ_SHORT = 4'd8;
	localparam logic [3:0] OP_READ_LONG  = 4'd9;

	localparam logic [5:0]  MAX_BITS      = 6'd32;
	localparam logic [10:0] MAX_SIZE_RST  = 11'd1024;
	localparam logic [31:0] READ_FAIL_VAL = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CH_A,
		ST_CH_B,
		ST_BY_A,
		ST_BY_B,
		ST_FIN
	} state_t;

endpackage

@@ hw/rtl/bpmb_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
module bpmb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ hw/rtl/bit_packed_message_buffer.sv @@
// Top level of the bit-packed message buffer: sequencer, pointers and byte store.
//
// The buffer holds bytes that are written and read as an LSB-first bit stream
// and as whole bytes, and also read as little-endian signed shorts and longs.
// Commands arrive on the input channel (in_valid / in_ready) as an opcode, a
// write value and a bit count. Every command gives exactly one result transfer
// on the output channel (out_valid / out_ready): the value read, a failure bit,
// the sticky overflow flag and the number of bytes in use.
// The byte store is one single-port RAM with a registered read. Bit commands
// walk the stream one byte at a time: each touched byte gets an address and
// read step (CH_A), then a merge-and-write or extract step (CH_B). Byte reads
// take an address step and an accumulate step per byte; clear, begin_read,
// write_byte and refused commands go from EXEC straight to FIN. One command
// is in flight at a time; in_ready is high only while the sequencer is idle.
// When the receiver stalls, the last result waits in the output register and
// the sequencer holds the new one in ST_FIN until that register frees up.
// Reset empties the buffer, zeroes the pointers and the overflow flag, and
// sets max_size to 1024. Stored bytes are not cleared; no clearing pass runs.
// cfg_we writes max_size and is taken in any cycle.
module bit_packed_message_buffer #(
	parameter int BUF_BYTES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [10:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         opcode,
	input  logic signed [31:0] write_value,
	input  logic [5:0]         bit_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] read_value,
	output logic               op_failed,
	output logic               overflow_flag,
	output logic [10:0]        used_bytes
);

	localparam int AW  = $clog2(BUF_BYTES);
	localparam int SZW = $clog2(BUF_BYTES + 1);
	localparam int BPW = SZW + 3;

	bpmb_pkg::state_t state_q, state_d;

	logic [10:0]    max_size_q;
	logic [3:0]     op_q;
	logic [31:0]    wv_q;
	logic [5:0]     n_q, n_d;
	logic [5:0]     i_q, i_d;
	logic [2:0]     j_q, j_d;
	logic [2:0]     nb_q, nb_d;
	logic           start_q, start_d;
	logic [SZW-1:0] ws_q, ws_d;
	logic [SZW-1:0] rp_q, rp_d;
	logic [BPW-1:0] bp_q, bp_d;
	logic           ovf_q, ovf_d;
	logic [31:0]    rv_q, rv_d;
	logic           fail_q, fail_d;

	logic [SZW-1:0] lim;
	logic           is_wr;
	logic           exec_fin;
	logic           chunk_end;
	logic           chunk_done;
	logic           bytes_done;
	logic           out_free;

	logic [AW-1:0]  mem_addr;
	logic           mem_we;
	logic [7:0]     mem_wdata;
	logic [7:0]     mem_rdata;

	logic [2:0]     off;
	logic [3:0]     room;
	logic [5:0]     k;
	logic [7:0]     low_mask;
	logic [15:0]    mask_w;
	logic [31:0]    wv_sh;
	logic [15:0]    seg_w;
	logic [7:0]     rbits;
	logic [31:0]    by_acc;

	bpmb_ram #(
		.WIDTH(8),
		.DEPTH(BUF_BYTES)
	) u_ram (
		.clk  (clk),
		.addr (mem_addr),
		.we   (mem_we),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// A limit above the store size behaves as the store size.
	assign lim = (32'(max_size_q) > 32'(BUF_BYTES)) ? SZW'(BUF_BYTES) : SZW'(max_size_q);
	assign is_wr = (op_q == bpmb_pkg::OP_WRITE_BITS) || (op_q == bpmb_pkg::OP_WRITE_BIT);
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == bpmb_pkg::ST_IDLE);

	// Bits of the current byte handled in this chunk.
	assign off      = bp_q[2:0];
	assign room     = 4'd8 - {1'b0, off};
	assign k        = (n_q < {2'b0, room}) ? n_q : {2'b0, room};
	assign low_mask = 8'((9'd1 << k) - 9'd1);
	assign mask_w   = {8'd0, low_mask} << off;
	assign wv_sh    = wv_q >> i_q;
	assign seg_w    = {8'd0, wv_sh[7:0]} << off;
	assign rbits    = (mem_rdata >> off) & low_mask;
	assign by_acc   = rv_q | (32'(mem_rdata) << {j_q, 3'b000});

	// Datapath and memory control.
	always_comb begin
		ws_d      = ws_q;
		rp_d      = rp_q;
		bp_d      = bp_q;
		ovf_d     = ovf_q;
		rv_d      = rv_q;
		fail_d    = fail_q;
		n_d       = n_q;
		i_d       = i_q;
		j_d       = j_q;
		nb_d      = nb_q;
		start_d   = start_q;
		mem_addr  = AW'(bp_q[BPW-1:3]);
		mem_we    = 1'b0;
		mem_wdata = 8'd0;
		exec_fin  = 1'b1;
		chunk_end = 1'b0;
		chunk_done = 1'b0;
		bytes_done = 1'b0;
		case (state_q)
			bpmb_pkg::ST_IDLE: begin
				// A count above 32 saturates when the command is taken.
				if (in_valid) begin
					n_d = (bit_count > bpmb_pkg::MAX_BITS) ? bpmb_pkg::MAX_BITS : bit_count;
				end
			end
			bpmb_pkg::ST_EXEC: begin
				rv_d   = 32'd0;
				fail_d = 1'b0;
				i_d    = 6'd0;
				j_d    = 3'd0;
				case (op_q)
					bpmb_pkg::OP_CLEAR: begin
						ws_d  = '0;
						bp_d  = '0;
						ovf_d = 1'b0;
					end
					bpmb_pkg::OP_WRITE_BITS: begin
						if ((SZW+1)'(ws_q) + (SZW+1)'(4) > (SZW+1)'(lim)) begin
							ovf_d  = 1'b1;
							fail_d = 1'b1;
						end else begin
							n_d      = n_q;
							exec_fin = (n_q == 6'd0);
						end
					end
					bpmb_pkg::OP_WRITE_BIT: begin
						if (ws_q >= lim) begin
							ovf_d  = 1'b1;
							fail_d = 1'b1;
						end else begin
							n_d      = 6'd1;
							exec_fin = 1'b0;
						end
					end
					bpmb_pkg::OP_WRITE_BYTE: begin
						if (ws_q >= lim) begin
							ovf_d  = 1'b1;
							fail_d = 1'b1;
						end else begin
							mem_addr  = AW'(ws_q);
							mem_we    = 1'b1;
							mem_wdata = wv_q[7:0];
							ws_d      = ws_q + 1'b1;
						end
					end
					bpmb_pkg::OP_BEGIN_READ: begin
						ovf_d = 1'b0;
						rp_d  = '0;
						bp_d  = '0;
					end
					bpmb_pkg::OP_READ_BITS: begin
						exec_fin = (n_q == 6'd0);
					end
					bpmb_pkg::OP_READ_BIT: begin
						n_d      = 6'd1;
						exec_fin = 1'b0;
					end
					bpmb_pkg::OP_READ_BYTE, bpmb_pkg::OP_READ_SHORT,
					bpmb_pkg::OP_READ_LONG: begin
						if (op_q == bpmb_pkg::OP_READ_BYTE) begin
							nb_d = 3'd1;
						end else if (op_q == bpmb_pkg::OP_READ_SHORT) begin
							nb_d = 3'd2;
						end else begin
							nb_d = 3'd4;
						end
						if ((SZW+1)'(rp_q) + (SZW+1)'(nb_d) > (SZW+1)'(ws_q)) begin
							ovf_d  = 1'b1;
							fail_d = 1'b1;
							rv_d   = bpmb_pkg::READ_FAIL_VAL;
						end else begin
							exec_fin = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			bpmb_pkg::ST_CH_A: begin
				// On a byte boundary the pointer moves to the next byte of the stream.
				start_d = 1'b0;
				if (off == 3'd0) begin
					if (is_wr) begin
						mem_addr = AW'(ws_q);
						bp_d     = {ws_q, 3'b000};
						ws_d     = ws_q + 1'b1;
						start_d  = 1'b1;
					end else if (rp_q >= ws_q) begin
						chunk_end = 1'b1;
						ovf_d     = 1'b1;
						fail_d    = 1'b1;
						rv_d      = bpmb_pkg::READ_FAIL_VAL;
					end else begin
						mem_addr = AW'(rp_q);
						bp_d     = {rp_q, 3'b000};
						rp_d     = rp_q + 1'b1;
					end
				end
			end
			bpmb_pkg::ST_CH_B: begin
				if (is_wr) begin
					mem_we    = 1'b1;
					mem_wdata = (start_q ? 8'd0 : mem_rdata) | (seg_w[7:0] & mask_w[7:0]);
				end else begin
					rv_d = rv_q | (32'(rbits) << i_q);
				end
				bp_d = bp_q + BPW'(k);
				i_d  = i_q + k;
				n_d  = n_q - k;
				chunk_done = (n_q == k);
			end
			bpmb_pkg::ST_BY_A: begin
				mem_addr = AW'(rp_q + SZW'(j_q));
			end
			bpmb_pkg::ST_BY_B: begin
				rv_d = by_acc;
				j_d  = j_q + 1'b1;
				if (j_d == nb_q) begin
					bytes_done = 1'b1;
					rp_d = rp_q + SZW'(nb_q);
					if (nb_q == 3'd2) begin
						rv_d = {{16{by_acc[15]}}, by_acc[15:0]};
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bpmb_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = bpmb_pkg::ST_EXEC;
				end
			end
			bpmb_pkg::ST_EXEC: begin
				if (exec_fin) begin
					state_d = bpmb_pkg::ST_FIN;
				end else if ((op_q == bpmb_pkg::OP_READ_BYTE) ||
						(op_q == bpmb_pkg::OP_READ_SHORT) ||
						(op_q == bpmb_pkg::OP_READ_LONG)) begin
					state_d = bpmb_pkg::ST_BY_A;
				end else begin
					state_d = bpmb_pkg::ST_CH_A;
				end
			end
			bpmb_pkg::ST_CH_A: begin
				state_d = chunk_end ? bpmb_pkg::ST_FIN : bpmb_pkg::ST_CH_B;
			end
			bpmb_pkg::ST_CH_B: begin
				state_d = chunk_done ? bpmb_pkg::ST_FIN : bpmb_pkg::ST_CH_A;
			end
			bpmb_pkg::ST_BY_A: begin
				state_d = bpmb_pkg::ST_BY_B;
			end
			bpmb_pkg::ST_BY_B: begin
				state_d = bytes_done ? bpmb_pkg::ST_FIN : bpmb_pkg::ST_BY_A;
			end
			bpmb_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = bpmb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bpmb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bpmb_pkg::ST_IDLE;
			max_size_q <= bpmb_pkg::MAX_SIZE_RST;
			ws_q       <= '0;
			rp_q       <= '0;
			bp_q       <= '0;
			ovf_q      <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			ws_q    <= ws_d;
			rp_q    <= rp_d;
			bp_q    <= bp_d;
			ovf_q   <= ovf_d;
			if (cfg_we) begin
				max_size_q <= cfg_wdata;
			end
			if (state_q == bpmb_pkg::ST_FIN && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		rv_q    <= rv_d;
		fail_q  <= fail_d;
		n_q     <= n_d;
		i_q     <= i_d;
		j_q     <= j_d;
		nb_q    <= nb_d;
		start_q <= start_d;
		if (in_valid && in_ready) begin
			op_q <= opcode;
			wv_q <= write_value;
		end
		if (state_q == bpmb_pkg::ST_FIN && out_free) begin
			read_value    <= rv_q;
			op_failed     <= fail_q;
			overflow_flag <= ovf_q;
			used_bytes    <= 11'(ws_q);
		end
	end

endmodule

@@ hw/rtl/bpmb_checker.sv @@
// Port-level checker for the bit-packed message buffer, bound to the top level.
module bpmb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] read_value,
	input logic               op_failed,
	input logic               overflow_flag
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(read_value) && $stable(op_failed))
		else $error("stalled result changed");

	// Every failure also raises the sticky flag.
	a_fail_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_failed |-> overflow_flag)
		else $error("failure without overflow flag");

	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_failed |-> read_value == -32'sd1 || read_value == 32'sd0)
		else $error("failed command returned data");

	// One command at a time: a transfer makes the block busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command taken while busy");

endmodule

bind bit_packed_message_buffer bpmb_checker u_bpmb_checker (.*);

@@ tb/bpmb_checker.sv @@
// Checker for the bit-packed message buffer: predicts each result and compares it field by field.
`timescale 1ns / 100ps

module bpmb_tb_checker #(
	parameter int BUF_BYTES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [10:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [3:0]         opcode,
	input  logic signed [31:0] write_value,
	input  logic [5:0]         bit_count,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] read_value,
	input  logic               op_failed,
	input  logic               overflow_flag,
	input  logic [10:0]        used_bytes,
	output int                 pending,
	output int                 fail_count
);

	typedef struct packed {
		logic signed [31:0] value;
		logic               failed;
		logic               ovf;
		logic [10:0]        used;
	} buf_result_t;

	logic [7:0]  store_mem [BUF_BYTES];
	int unsigned wsize, rpos, bitpos, max_bytes;
	logic        ovf_state;
	buf_result_t awaited_q [$];

	// Starts a new byte when the shared bit pointer sits on a byte boundary.
	task automatic open_write_byte();
		if (bitpos[2:0] == 3'd0) begin
			bitpos = wsize * 8;
			if (wsize < BUF_BYTES) store_mem[wsize] = 8'h00;
			wsize++;
		end
	endtask

	task automatic put_bit(input logic b);
		open_write_byte();
		if (b && (bitpos >> 3) < BUF_BYTES) store_mem[bitpos >> 3][bitpos[2:0]] = 1'b1;
		bitpos++;
	endtask

	function automatic logic [7:0] peek(input int unsigned idx);
		return (idx < BUF_BYTES) ? store_mem[idx] : 8'h00;
	endfunction

	// Pulls bits off the read side; clears ok at end of data, keeping the progress made.
	task automatic take_bits(input int unsigned n, output logic ok, output logic [31:0] v);
		logic [7:0] cur;
		v = '0;
		ok = 1'b1;
		for (int unsigned i = 0; i < n; i++) begin
			if (bitpos[2:0] == 3'd0) begin
				if (rpos >= wsize) begin
					ovf_state = 1'b1;
					ok = 1'b0;
					return;
				end
				bitpos = rpos * 8;
				rpos++;
			end
			cur = peek(bitpos >> 3);
			v[i] = cur[bitpos[2:0]];
			bitpos++;
		end
	endtask

	task automatic predict_command(input logic [3:0] op, input logic [31:0] wv,
			input logic [5:0] cnt_in, output buf_result_t r);
		int unsigned lim, cnt, need;
		logic [31:0] v;
		logic ok;
		lim = (max_bytes > BUF_BYTES) ? BUF_BYTES : max_bytes;
		cnt = (cnt_in > bpmb_pkg::MAX_BITS) ? 32 : cnt_in;
		v = '0;
		ok = 1'b1;
		case (op)
			bpmb_pkg::OP_CLEAR: begin
				wsize = 0;
				bitpos = 0;
				ovf_state = 1'b0;
			end
			bpmb_pkg::OP_WRITE_BITS: begin
				if (wsize + 4 > lim) begin
					ovf_state = 1'b1;
					ok = 1'b0;
				end else begin
					for (int unsigned i = 0; i < cnt; i++) put_bit(wv[i]);
				end
			end
			bpmb_pkg::OP_WRITE_BIT, bpmb_pkg::OP_WRITE_BYTE: begin
				if (wsize >= lim) begin
					ovf_state = 1'b1;
					ok = 1'b0;
				end else if (op == bpmb_pkg::OP_WRITE_BIT) begin
					put_bit(wv[0]);
				end else begin
					if (wsize < BUF_BYTES) store_mem[wsize] = wv[7:0];
					wsize++;
				end
			end
			bpmb_pkg::OP_BEGIN_READ: begin
				ovf_state = 1'b0;
				rpos = 0;
				bitpos = 0;
			end
			bpmb_pkg::OP_READ_BITS, bpmb_pkg::OP_READ_BIT: begin
				take_bits((op == bpmb_pkg::OP_READ_BIT) ? 1 : cnt, ok, v);
				if (!ok) v = bpmb_pkg::READ_FAIL_VAL;
			end
			bpmb_pkg::OP_READ_BYTE, bpmb_pkg::OP_READ_SHORT, bpmb_pkg::OP_READ_LONG: begin
				need = (op == bpmb_pkg::OP_READ_BYTE) ? 1 :
					(op == bpmb_pkg::OP_READ_SHORT) ? 2 : 4;
				if (rpos + need > wsize) begin
					ovf_state = 1'b1;
					ok = 1'b0;
					v = bpmb_pkg::READ_FAIL_VAL;
				end else begin
					for (int unsigned k = 0; k < need; k++) v[8*k +: 8] = peek(rpos + k);
					// Shorts come back sign-extended; bytes do not.
					if (op == bpmb_pkg::OP_READ_SHORT && v[15]) v[31:16] = 16'hFFFF;
					rpos += need;
				end
			end
			default: ;
		endcase
		// Refused writes report zero; failed reads carry the all-ones value set above.
		r.value  = v;
		r.failed = ~ok;
		r.ovf    = ovf_state;
		r.used   = wsize[10:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		buf_result_t exp_r, got_r;
		if (!arst_n) begin
			wsize = 0;
			rpos = 0;
			bitpos = 0;
			ovf_state = 1'b0;
			max_bytes = bpmb_pkg::MAX_SIZE_RST;
			awaited_q.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			// The result is retired before a new command is predicted in the same cycle.
			if (out_valid && out_ready) begin
				got_r = '{read_value, op_failed, overflow_flag, used_bytes};
				if (awaited_q.size() == 0) begin
					$display("%0t: result transfer with nothing awaited: %h", $time, got_r);
					fail_count++;
				end else begin
					exp_r = awaited_q.pop_front();
					if (got_r.value !== exp_r.value) begin
						$display("%0t: read_value expected %h actual %h", $time,
							exp_r.value, got_r.value);
						fail_count++;
					end
					if (got_r.failed !== exp_r.failed) begin
						$display("%0t: op_failed expected %b actual %b", $time,
							exp_r.failed, got_r.failed);
						fail_count++;
					end
					if (got_r.ovf !== exp_r.ovf) begin
						$display("%0t: overflow_flag expected %b actual %b", $time,
							exp_r.ovf, got_r.ovf);
						fail_count++;
					end
					if (got_r.used !== exp_r.used) begin
						$display("%0t: used_bytes expected %0d actual %0d", $time,
							exp_r.used, got_r.used);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_command(opcode, write_value, bit_count, exp_r);
				awaited_q.push_back(exp_r);
			end
			if (cfg_we) max_bytes = cfg_wdata;
			pending = awaited_q.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// Testbench top for the bit-packed message buffer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [10:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [3:0]         opcode = bpmb_pkg::OP_CLEAR;
	logic signed [31:0] write_value = '0;
	logic [5:0]         bit_count = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] read_value;
	logic               op_failed;
	logic               overflow_flag;
	logic [10:0]        used_bytes;
	int                 pending;
	int                 fail_count;
	int                 cycle_count = 0;
	// When set, neither side idles, so the block runs back to back.
	logic               no_idle = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bit_packed_message_buffer i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.write_value(write_value), .bit_count(bit_count), .out_valid(out_valid),
		.out_ready(out_ready), .read_value(read_value), .op_failed(op_failed),
		.overflow_flag(overflow_flag), .used_bytes(used_bytes)
	);

	bpmb_tb_checker i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.write_value(write_value), .bit_count(bit_count), .out_valid(out_valid),
		.out_ready(out_ready), .read_value(read_value), .op_failed(op_failed),
		.overflow_flag(overflow_flag), .used_bytes(used_bytes),
		.pending(pending), .fail_count(fail_count)
	);

	// Sends one command. The ready line is looked at in the middle of the cycle so the
	// decision never races with the edge; the caller is left at the edge of the transfer.
	task automatic send_cmd(input logic [3:0] op, input logic [31:0] wv, input logic [5:0] cnt);
		int gap;
		logic taken;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		write_value <= wv;
		bit_count <= cnt;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// The receiver holds off for a random number of cycles before each result.
	always begin
		int stall;
		logic taken;
		@(posedge clk);
		if (arst_n) begin
			stall = no_idle ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				taken = out_valid;
				@(posedge clk);
			end while (!taken);
		end
	end

	// A new limit is written only once every awaited result has come back.
	task automatic set_limit(input logic [10:0] v);
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [5:0] pick_count();
		return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
			: 6'($urandom_range(0, 32));
	endfunction

	// Mostly well-formed traffic: a run of writes, a rewind, then a run of reads that
	// often walks off the end of the data. About one command in ten is pure noise.
	task automatic random_traffic(input int n_items);
		int sent, n_wr, n_rd;
		logic [3:0] op;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 3) == 0) begin
				send_cmd(bpmb_pkg::OP_CLEAR, $urandom, pick_count());
				sent++;
			end
			n_wr = $urandom_range(1, 12);
			for (int k = 0; k < n_wr; k++) begin
				case ($urandom_range(0, 9))
					0:       op = 4'($urandom_range(0, 15));
					1, 2, 3: op = bpmb_pkg::OP_WRITE_BIT;
					4, 5:    op = bpmb_pkg::OP_WRITE_BYTE;
					default: op = bpmb_pkg::OP_WRITE_BITS;
				endcase
				send_cmd(op, $urandom, pick_count());
			end
			send_cmd(bpmb_pkg::OP_BEGIN_READ, $urandom, pick_count());
			n_rd = $urandom_range(1, 14);
			for (int k = 0; k < n_rd; k++) begin
				case ($urandom_range(0, 11))
					0:       op = 4'($urandom_range(0, 15));
					1, 2:    op = bpmb_pkg::OP_READ_BITS;
					3, 4:    op = bpmb_pkg::OP_READ_BIT;
					5, 6:    op = bpmb_pkg::OP_READ_BYTE;
					7, 8:    op = bpmb_pkg::OP_READ_SHORT;
					9, 10:   op = bpmb_pkg::OP_READ_LONG;
					default: op = 4'($urandom_range(bpmb_pkg::OP_WRITE_BITS,
						bpmb_pkg::OP_WRITE_BYTE));
				endcase
				send_cmd(op, $urandom, pick_count());
			end
			sent += n_wr + n_rd + 1;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset limit of 1024 bytes: field extremes, every opcode,
		// saturated counts, the zero-count read and the ends of data.
		send_cmd(bpmb_pkg::OP_WRITE_BITS, 32'h8000_0001, 6'd32);
		send_cmd(bpmb_pkg::OP_WRITE_BITS, 32'hFFFF_FFFF, 6'd0);
		send_cmd(bpmb_pkg::OP_WRITE_BITS, 32'h7FFF_FFFE, 6'd63);
		send_cmd(bpmb_pkg::OP_WRITE_BIT, 32'h0000_0001, 6'd0);
		send_cmd(bpmb_pkg::OP_WRITE_BITS, 32'h0000_0055, 6'd7);
		send_cmd(bpmb_pkg::OP_WRITE_BYTE, 32'h0000_0080, 6'd0);
		send_cmd(bpmb_pkg::OP_WRITE_BYTE, 32'hFFFF_FFFF, 6'd0);
		send_cmd(4'd15, 32'hFFFF_FFFF, 6'd63);
		send_cmd(bpmb_pkg::OP_BEGIN_READ, 32'd0, 6'd0);
		send_cmd(bpmb_pkg::OP_READ_BITS, 32'd0, 6'd0);
		send_cmd(bpmb_pkg::OP_READ_BITS, 32'd0, 6'd32);
		send_cmd(bpmb_pkg::OP_READ_BIT, 32'd0, 6'd0);
		send_cmd(bpmb_pkg::OP_READ_BITS, 32'd0, 6'd40);
		send_cmd(bpmb_pkg::OP_READ_BYTE, 32'd0, 6'd0);
		send_cmd(bpmb_pkg::OP_READ_SHORT, 32'd0, 6'd0);
		send_cmd(bpmb_pkg::OP_READ_LONG, 32'd0, 6'd0);
		send_cmd(bpmb_pkg::OP_READ_BITS, 32'd0, 6'd32);
		send_cmd(bpmb_pkg::OP_READ_BYTE, 32'd0, 6'd0);
		send_cmd(bpmb_pkg::OP_CLEAR, 32'd0, 6'd0);
		send_cmd(bpmb_pkg::OP_READ_SHORT, 32'd0, 6'd0);

		// A five-byte limit: the second bit write is refused, then the single-byte
		// writes fill the buffer and are refused once it is full.
		set_limit(11'd5);
		send_cmd(bpmb_pkg::OP_CLEAR, 32'd0, 6'd0);
		send_cmd(bpmb_pkg::OP_WRITE_BITS, 32'h1234_5678, 6'd16);
		send_cmd(bpmb_pkg::OP_WRITE_BITS, 32'h1234_5678, 6'd0);
		repeat (4) send_cmd(bpmb_pkg::OP_WRITE_BYTE, $urandom, 6'd0);
		send_cmd(bpmb_pkg::OP_WRITE_BIT, 32'd1, 6'd0);

		// Random traffic over a range of limits, the extremes among them.
		set_limit(11'd1024);
		random_traffic(150);
		no_idle = 1'b1;
		set_limit(11'd0);
		random_traffic(60);
		no_idle = 1'b0;
		set_limit(11'd2047);
		random_traffic(150);
		set_limit(11'd4);
		random_traffic(80);
		set_limit(11'd7);
		random_traffic(100);
		no_idle = 1'b1;
		set_limit(11'd1030);
		random_traffic(100);
		no_idle = 1'b0;
		set_limit(11'd24);
		random_traffic(150);
		set_limit(11'd300);
		random_traffic(110);

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS bit_packed_message_buffer");
		end else begin
			$display("FAIL bit_packed_message_buffer");
		end
		$finish;
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL bit_packed_message_buffer");
			$finish;
		end
	end

endmodule
